// File: sv/tns_pkg.sv
// Shared widths, defaults and codes for the nearest-texel sampler.
package tns_pkg;

  localparam int DIM_W     = 9;
  localparam int IDX_W     = 2 * DIM_W;
  localparam int COORD_W   = 24;
  localparam int ADDR_IN_W = 16;
  localparam int CHAN_W    = 8;
  localparam int TEXEL_W   = 3 * CHAN_W;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_DIM_DEF     = 256;
  localparam int TEXEL_DEPTH_DEF = 65536;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_S   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_T   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT    = 3'd4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PICK  = 1'b1;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t OP_MUL = 2'd0;
  localparam alu_op_t OP_MIN = 2'd1;
  localparam alu_op_t OP_ADD = 2'd2;
  localparam alu_op_t OP_SUB = 2'd3;

  typedef struct packed {
    logic    en;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic we;
    logic re;
  } store_req_t;

endpackage

// File: sv/tns_alu.sv
// Shared arithmetic unit: multiply, index saturate, add and conditional subtract.
module tns_alu
  import tns_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int PROD_W    = FRAC_BITS_DEF + 1 + DIM_W
) (
  input  logic              clk,
  input  alu_ctl_t          ctl,
  input  logic [PROD_W-1:0] a,
  input  logic [PROD_W-1:0] b,
  output logic [PROD_W-1:0] res
);

  logic [PROD_W-1:0] res_r;
  logic [PROD_W-1:0] res_nxt;
  logic [PROD_W-1:0] prod;
  logic [DIM_W:0]    t;
  logic [DIM_W:0]    lim;

  assign prod = PROD_W'(a[FRAC_BITS:0]) * PROD_W'(b[DIM_W-1:0]);
  assign t    = a[PROD_W-1:FRAC_BITS];
  assign lim  = {1'b0, b[DIM_W-1:0]} - {{DIM_W{1'b0}}, 1'b1};

  always_comb begin
    unique case (ctl.op)
      OP_MUL: res_nxt = prod;
      OP_MIN: res_nxt = PROD_W'((t > lim) ? lim : t);
      OP_ADD: res_nxt = a + b;
      OP_SUB: res_nxt = (a >= b) ? (a - b) : a;
      default: res_nxt = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: sv/tns_store.sv
// Texel memory: one write port, one registered read port.
module tns_store
  import tns_pkg::*;
#(
  parameter int DEPTH  = TEXEL_DEPTH_DEF,
  parameter int ADDR_W = $clog2(TEXEL_DEPTH_DEF)
) (
  input  logic               clk,
  input  store_req_t         req,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [TEXEL_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [TEXEL_W-1:0] rdata
);

  logic [TEXEL_W-1:0] mem [DEPTH];
  logic [TEXEL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/texture_nearest_sample.sv
// Top level: nearest-texel sampler with sequencer, shared ALU and texel memory.
//
//  channel  ports                              handshake
//  request  start, busy, in_*                  taken when start & !busy
//  result   out_strobe, out_*                  one cycle, cannot be held off
//  config   cfg_we, cfg_index, cfg_data        written when cfg_we
//
// A write request is stored at the edge that takes it. A pick without a texture
// answers in the next cycle. A pick with a texture steps through the shared ALU
// (two scale multiplies, two saturations, row multiply, add, N modulo steps),
// memory read and capture, N = 0 when TEXEL_DEPTH covers the full index range;
// the result shows in the cycle after the capture. Reset is synchronous; the memory
// is not cleared. busy is high while a pick runs; the result side never stalls.
module texture_nearest_sample
  import tns_pkg::*;
#(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int TEXEL_DEPTH = TEXEL_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_command,
  input  logic [ADDR_IN_W-1:0]       in_texel_address,
  input  logic [CHAN_W-1:0]          in_texel_red,
  input  logic [CHAN_W-1:0]          in_texel_green,
  input  logic [CHAN_W-1:0]          in_texel_blue,
  input  logic signed [COORD_W-1:0]  in_coord_u,
  input  logic signed [COORD_W-1:0]  in_coord_v,
  output logic                       out_strobe,
  output logic [CHAN_W-1:0]          out_red,
  output logic [CHAN_W-1:0]          out_green,
  output logic [CHAN_W-1:0]          out_blue,
  output logic                       out_color_valid,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int ADDR_W  = $clog2(TEXEL_DEPTH);
  localparam int PROD_W  = FRAC_BITS + 1 + DIM_W;
  localparam int CX_W    = COORD_W + 2;
  localparam int LOG_DEP = $clog2(TEXEL_DEPTH + 1) - 1;
  localparam int NSTEP   = (IDX_W > LOG_DEP) ? (IDX_W - LOG_DEP) : 0;
  localparam int KW      = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int SH_W    = PROD_W + COORD_W + 1;
  localparam logic [SH_W-1:0] DEPTH_X = SH_W'(TEXEL_DEPTH);
  localparam logic signed [CX_W-1:0] ONE_FIX = CX_W'(1) <<< FRAC_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_SX   = 4'd2;
  localparam logic [3:0] S_MY   = 4'd3;
  localparam logic [3:0] S_SY   = 4'd4;
  localparam logic [3:0] S_MI   = 4'd5;
  localparam logic [3:0] S_AD   = 4'd6;
  localparam logic [3:0] S_MD   = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_DT   = 4'd9;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic logic [FRAC_BITS:0] frac_of(input logic signed [CX_W-1:0] c,
                                                 input logic wrap);
    logic [FRAC_BITS:0] f;
    if (wrap) begin
      f = {1'b0, c[FRAC_BITS-1:0]};
    end else if (c < 0) begin
      f = '0;
    end else if (c > ONE_FIX) begin
      f = {1'b1, {FRAC_BITS{1'b0}}};
    end else begin
      f = c[FRAC_BITS:0];
    end
    return f;
  endfunction

  logic [DIM_W-1:0] width_r, height_r;
  logic             rep_s_r, rep_t_r, present_r;

  logic [3:0]          state_r, state_nxt;
  logic [FRAC_BITS:0]  fu_r, fu_nxt, fv_r, fv_nxt;
  logic [DIM_W-1:0]    x_r, x_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic                strobe_r, strobe_nxt;
  logic                cvalid_r, cvalid_nxt;
  logic [TEXEL_W-1:0]  color_r, color_nxt;

  logic [DIM_W-1:0]    w_eff, h_eff;
  logic                accept;
  logic                wr_in_range;
  logic [ADDR_W+ADDR_IN_W-1:0] waddr_x;
  logic [ADDR_W+PROD_W-1:0]    raddr_x;

  alu_ctl_t            alu_ctl;
  logic [PROD_W-1:0]   alu_a, alu_b, alu_res;
  store_req_t          st_req;
  logic [TEXEL_W-1:0]  st_rdata;

  assign w_eff       = eff_dim(width_r);
  assign h_eff       = eff_dim(height_r);
  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;
  assign wr_in_range = (32'(in_texel_address) < TEXEL_DEPTH);
  assign waddr_x     = (ADDR_W + ADDR_IN_W)'(in_texel_address);
  assign raddr_x     = (ADDR_W + PROD_W)'(alu_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DIM_W'(1);
      height_r  <= DIM_W'(1);
      rep_s_r   <= 1'b1;
      rep_t_r   <= 1'b1;
      present_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEX_WIDTH:  width_r   <= cfg_data[DIM_W-1:0];
        CFG_TEX_HEIGHT: height_r  <= cfg_data[DIM_W-1:0];
        CFG_REPEAT_S:   rep_s_r   <= cfg_data[0];
        CFG_REPEAT_T:   rep_t_r   <= cfg_data[0];
        CFG_PRESENT:    present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    fu_nxt      = fu_r;
    fv_nxt      = fv_r;
    x_nxt       = x_r;
    k_nxt       = k_r;
    strobe_nxt  = 1'b0;
    cvalid_nxt  = cvalid_r;
    color_nxt   = color_r;
    alu_ctl.en  = 1'b0;
    alu_ctl.op  = OP_MUL;
    alu_a       = alu_res;
    alu_b       = PROD_W'(w_eff);
    st_req.we   = 1'b0;
    st_req.re   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_WRITE) begin
            st_req.we = wr_in_range;
          end else if (!present_r) begin
            strobe_nxt = 1'b1;
            cvalid_nxt = 1'b0;
            color_nxt  = '0;
          end else begin
            fu_nxt    = frac_of(CX_W'(in_coord_u), rep_s_r);
            fv_nxt    = frac_of(CX_W'(in_coord_v), rep_t_r);
            state_nxt = S_MX;
          end
        end
      end
      S_MX: begin
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_MUL;
        alu_a      = PROD_W'(fu_r);
        state_nxt  = S_SX;
      end
      S_SX: begin
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_MIN;
        state_nxt  = S_MY;
      end
      S_MY: begin
        x_nxt      = alu_res[DIM_W-1:0];
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_MUL;
        alu_a      = PROD_W'(fv_r);
        alu_b      = PROD_W'(h_eff);
        state_nxt  = S_SY;
      end
      S_SY: begin
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_MIN;
        alu_b      = PROD_W'(h_eff);
        state_nxt  = S_MI;
      end
      S_MI: begin
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_MUL;
        state_nxt  = S_AD;
      end
      S_AD: begin
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_ADD;
        alu_b      = PROD_W'(x_r);
        k_nxt      = KW'(NSTEP - 1);
        state_nxt  = (NSTEP > 0) ? S_MD : S_RD;
      end
      S_MD: begin
        // restoring reduction of the linear index modulo the store depth
        alu_ctl.en = 1'b1;
        alu_ctl.op = OP_SUB;
        alu_b      = PROD_W'(DEPTH_X << k_r);
        if (k_r == '0) begin
          state_nxt = S_RD;
        end else begin
          k_nxt = k_r - KW'(1);
        end
      end
      S_RD: begin
        st_req.re = 1'b1;
        state_nxt = S_DT;
      end
      S_DT: begin
        strobe_nxt = 1'b1;
        cvalid_nxt = 1'b1;
        color_nxt  = st_rdata;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fu_r     <= fu_nxt;
    fv_r     <= fv_nxt;
    x_r      <= x_nxt;
    k_r      <= k_nxt;
    cvalid_r <= cvalid_nxt;
    color_r  <= color_nxt;
  end

  tns_alu #(
    .FRAC_BITS (FRAC_BITS),
    .PROD_W    (PROD_W)
  ) u_alu (
    .clk (clk),
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  tns_store #(
    .DEPTH  (TEXEL_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .req   (st_req),
    .waddr (waddr_x[ADDR_W-1:0]),
    .wdata ({in_texel_red, in_texel_green, in_texel_blue}),
    .raddr (raddr_x[ADDR_W-1:0]),
    .rdata (st_rdata)
  );

  assign out_strobe      = strobe_r;
  assign out_color_valid = cvalid_r;
  assign out_red         = color_r[TEXEL_W-1:2*CHAN_W];
  assign out_green       = color_r[2*CHAN_W-1:CHAN_W];
  assign out_blue        = color_r[CHAN_W-1:0];

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_DT ||
                         (accept && in_command == CMD_PICK && !present_r)))
    else $error("result strobe without a finished pick");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while a pick is still running");

  a_no_tex_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_color_valid) |->
      (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("invalid color is not black");

  a_mod_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MD) |-> (32'(k_r) < NSTEP))
    else $error("modulo step counter out of range");

endmodule

// File: tb/texture_nearest_sample_test.sv
// Self-checking testbench for the nearest-texel sampler: directed corners, then random traffic.
module texture_nearest_sample_test;
  import tns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE_FIX = 1 << FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              valid;
  } color_t;

  typedef struct {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             wrap_s;
    logic             wrap_t;
    logic             present;
  } tex_settings_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_command;
  logic [ADDR_IN_W-1:0]      in_texel_address;
  logic [CHAN_W-1:0]         in_texel_red;
  logic [CHAN_W-1:0]         in_texel_green;
  logic [CHAN_W-1:0]         in_texel_blue;
  logic signed [COORD_W-1:0] in_coord_u;
  logic signed [COORD_W-1:0] in_coord_v;
  logic                      out_strobe;
  logic [CHAN_W-1:0]         out_red;
  logic [CHAN_W-1:0]         out_green;
  logic [CHAN_W-1:0]         out_blue;
  logic                      out_color_valid;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  // sampler state as seen from outside
  logic [TEXEL_W-1:0] texel_mem [int];
  logic [DIM_W-1:0]   cur_width;
  logic [DIM_W-1:0]   cur_height;
  logic               cur_wrap_s;
  logic               cur_wrap_t;
  logic               cur_present;

  color_t pending_colors[$];
  int     mismatch_count;
  bit     no_gaps;

  texture_nearest_sample dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [COORD_W-1:0] coord(int v);
    return COORD_W'(v);
  endfunction

  function automatic int span(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(d);
  endfunction

  function automatic int axis_texel(logic signed [COORD_W-1:0] c, logic wrap, int dim);
    longint f;
    longint t;
    if (wrap) f = longint'(c) & (ONE_FIX - 1);
    else if (c < 0) f = 0;
    else if (longint'(c) > ONE_FIX) f = ONE_FIX;
    else f = longint'(c);
    t = (f * dim) >>> FRAC_BITS_DEF;
    if (t > dim - 1) t = dim - 1;
    return int'(t);
  endfunction

  function automatic int texel_index(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    int w;
    int x;
    int y;
    w = span(cur_width);
    x = axis_texel(u, cur_wrap_s, w);
    y = axis_texel(v, cur_wrap_t, span(cur_height));
    return (y * w + x) % TEXEL_DEPTH_DEF;
  endfunction

  function automatic void model_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_TEX_WIDTH:  cur_width = data[DIM_W-1:0];
      CFG_TEX_HEIGHT: cur_height = data[DIM_W-1:0];
      CFG_REPEAT_S:   cur_wrap_s = data[0];
      CFG_REPEAT_T:   cur_wrap_t = data[0];
      CFG_PRESENT:    cur_present = data[0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return COORD_W'(int'($urandom_range(0, 6 * ONE_FIX)) - 3 * ONE_FIX);
      5: return COORD_W'($urandom);
      6: return COORD_W'((int'($urandom_range(0, 4)) - 2) * ONE_FIX);
      7: return COORD_W'(ONE_FIX + int'($urandom_range(0, 2)) - 1);
      8: return COORD_W'(int'($urandom_range(0, 2)) - 1);
      default: return COORD_W'($urandom_range(0, ONE_FIX - 1));
    endcase
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    $display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // one request on the command port; returns at the clock edge it was taken or after its gap
  task automatic send_request(logic cmd, logic [ADDR_IN_W-1:0] addr, logic [TEXEL_W-1:0] rgb,
                              logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    int gap;
    logic [TEXEL_W-1:0] texel;
    start <= 1'b1;
    in_command <= cmd;
    in_texel_address <= addr;
    in_texel_red <= rgb[23:16];
    in_texel_green <= rgb[15:8];
    in_texel_blue <= rgb[7:0];
    in_coord_u <= u;
    in_coord_v <= v;
    do @(posedge clk); while (busy);
    if (cmd == CMD_WRITE) begin
      texel_mem[int'(addr)] = rgb;
    end else if (!cur_present) begin
      pending_colors.push_back('{red: '0, green: '0, blue: '0, valid: 1'b0});
    end else begin
      texel = texel_mem[texel_index(u, v)];
      pending_colors.push_back('{red: texel[23:16], green: texel[15:8], blue: texel[7:0],
                                 valid: 1'b1});
    end
    gap = no_gaps ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_texel(logic [ADDR_IN_W-1:0] addr, logic [TEXEL_W-1:0] rgb);
    send_request(CMD_WRITE, addr, rgb, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  // a pick never reads a texel that was never written: fill it first
  task automatic pick_color(logic signed [COORD_W-1:0] u, logic signed [COORD_W-1:0] v);
    int idx;
    idx = texel_index(u, v);
    if (cur_present && !texel_mem.exists(idx))
      write_texel(idx[ADDR_IN_W-1:0], TEXEL_W'($urandom));
    send_request(CMD_PICK, ADDR_IN_W'($urandom), TEXEL_W'($urandom), u, v);
  endtask

  task automatic settle_block();
    start <= 1'b0;
    while (pending_colors.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    model_register(idx, data);
  endtask

  task automatic apply_settings(tex_settings_t s);
    settle_block();
    put_register(CFG_TEX_WIDTH, s.width);
    put_register(CFG_TEX_HEIGHT, s.height);
    put_register(CFG_REPEAT_S, {8'($urandom_range(0, 255)), s.wrap_s});
    put_register(CFG_REPEAT_T, {8'($urandom_range(0, 255)), s.wrap_t});
    put_register(CFG_PRESENT, {8'($urandom_range(0, 255)), s.present});
    cfg_we <= 1'b0;
  endtask

  task automatic test_no_texture();
    write_texel('0, 24'h000000);
    write_texel('1, 24'hFFFFFF);
    pick_color(coord(0), coord(0));
    pick_color(COORD_MAX, COORD_MIN);
  endtask

  task automatic test_wrap_extremes();
    apply_settings('{width: DIM_W'(256), height: DIM_W'(256), wrap_s: 1'b1, wrap_t: 1'b1,
                     present: 1'b1});
    pick_color(COORD_MIN, COORD_MAX);
    pick_color(coord(-1), coord(-1));
    pick_color(coord(ONE_FIX - 1), coord(ONE_FIX));
    pick_color(coord(0), coord(0));
  endtask

  task automatic test_clamp_extremes();
    apply_settings('{width: DIM_W'(256), height: DIM_W'(256), wrap_s: 1'b0, wrap_t: 1'b0,
                     present: 1'b1});
    pick_color(COORD_MIN, COORD_MAX);
    pick_color(coord(ONE_FIX), coord(ONE_FIX + 1));
    pick_color(coord(ONE_FIX - 1), coord(-1));
    pick_color(coord(0), coord(ONE_FIX / 2));
  endtask

  task automatic test_odd_dimensions();
    // zero reads as one texel, anything past the maximum saturates
    apply_settings('{width: DIM_W'(0), height: DIM_W'(511), wrap_s: 1'b0, wrap_t: 1'b1,
                     present: 1'b1});
    pick_color(coord(ONE_FIX / 3), coord(-ONE_FIX / 4));
    pick_color(COORD_MAX, coord(ONE_FIX - 1));
    pick_color(coord(-ONE_FIX), coord(0));
    apply_settings('{width: DIM_W'(511), height: DIM_W'(0), wrap_s: 1'b1, wrap_t: 1'b0,
                     present: 1'b1});
    pick_color(coord(-ONE_FIX / 7), COORD_MAX);
    pick_color(coord(ONE_FIX - 1), COORD_MIN);
  endtask

  task automatic test_unused_registers();
    settle_block();
    for (int i = int'(CFG_PRESENT) + 1; i < 2 ** CFG_IDX_W; i++) begin
      put_register(i[CFG_IDX_W-1:0], '1);
    end
    cfg_we <= 1'b0;
    pick_color(coord(ONE_FIX / 2), coord(ONE_FIX / 2));
    pick_color(coord(-ONE_FIX / 2), coord(ONE_FIX + ONE_FIX / 2));
  endtask

  task automatic test_random_traffic(int phases, int per_phase);
    tex_settings_t s;
    int w;
    int h;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 9))
        0: s.width = DIM_W'($urandom_range(0, 1) ? 0 : $urandom_range(MAX_DIM_DEF + 1, 511));
        1: s.width = DIM_W'(MAX_DIM_DEF);
        2: s.width = DIM_W'(1);
        default: s.width = DIM_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 9))
        0: s.height = DIM_W'($urandom_range(0, 1) ? 0 : $urandom_range(MAX_DIM_DEF + 1, 511));
        1: s.height = DIM_W'(MAX_DIM_DEF);
        2: s.height = DIM_W'(1);
        default: s.height = DIM_W'($urandom_range(1, 64));
      endcase
      s.wrap_s = 1'($urandom_range(0, 1));
      s.wrap_t = 1'($urandom_range(0, 1));
      s.present = (p == 1) ? 1'b0 : 1'b1;
      apply_settings(s);
      no_gaps = (p % 3 == 2);
      w = span(cur_width);
      h = span(cur_height);
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          if ($urandom_range(0, 4) == 0)
            write_texel(ADDR_IN_W'($urandom), TEXEL_W'($urandom));
          else
            write_texel(ADDR_IN_W'($urandom_range(0, w * h - 1)), TEXEL_W'($urandom));
        end else begin
          pick_color(random_coord(), random_coord());
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    color_t want;
    if (rst_n && out_strobe) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("unexpected result", 0, 1);
      end else begin
        want = pending_colors.pop_front();
        if (out_red !== want.red) report_mismatch("red", int'(want.red), int'(out_red));
        if (out_green !== want.green)
          report_mismatch("green", int'(want.green), int'(out_green));
        if (out_blue !== want.blue) report_mismatch("blue", int'(want.blue), int'(out_blue));
        if (out_color_valid !== want.valid)
          report_mismatch("color_valid", int'(want.valid), int'(out_color_valid));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("** texture_nearest_sample: FAILED **");
    $finish;
  end

  initial begin
    int waited;
    mismatch_count = 0;
    no_gaps = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= CMD_WRITE;
    in_texel_address <= '0;
    in_texel_red <= '0;
    in_texel_green <= '0;
    in_texel_blue <= '0;
    in_coord_u <= '0;
    in_coord_v <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TEX_WIDTH;
    cfg_data <= '0;
    cur_width = DIM_W'(1);
    cur_height = DIM_W'(1);
    cur_wrap_s = 1'b1;
    cur_wrap_t = 1'b1;
    cur_present = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_texture();
    test_wrap_extremes();
    test_clamp_extremes();
    test_odd_dimensions();
    test_unused_registers();
    test_random_traffic(6, 80);

    start <= 1'b0;
    waited = 0;
    while (pending_colors.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_colors.size() != 0)
      report_mismatch("results never arrived", 0, pending_colors.size());
    if (mismatch_count == 0) begin
      $display("** texture_nearest_sample: PASSED **");
    end else begin
      $display("** texture_nearest_sample: FAILED **");
    end
    $finish;
  end

endmodule
